[rtl/ldr_pkg.sv]
// Shared types and codes for the lock directory block.
// Used by the controller, the datapath and the top level; no dependencies.
package ldr_pkg;

    // Lock modes as stored in a directory entry.
    localparam logic [1:0] MODE_ABSENT   = 2'd0;
    localparam logic [1:0] MODE_FREE     = 2'd1;
    localparam logic [1:0] MODE_GRANTED  = 2'd2;
    localparam logic [1:0] MODE_REVOKING = 2'd3;

    // Response status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RETRY     = 2'd1;
    localparam logic [1:0] ST_VIOLATION = 2'd2;

    // Callback message codes.
    localparam logic [1:0] MSG_NONE   = 2'd0;
    localparam logic [1:0] MSG_REVOKE = 2'd1;
    localparam logic [1:0] MSG_RETRY  = 2'd2;

    // Request kinds.
    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Request transaction payload.
    typedef struct packed {
        logic       kind;
        logic [7:0] lock_id;
        logic [5:0] client_id;
    } t_req;

    // Response transaction payload.
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] message;
        logic [5:0] message_client;
        logic [7:0] message_lock;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic exec;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_sts;

endpackage

[rtl/lock_directory_revoke_retry.sv]
// Top level of the lock directory with revoke and retry callbacks.
// Depends on ldr_pkg and instantiates ldr_ctrl and ldr_dp.
//
// Usage:
//   The request channel (i_in_valid, o_in_stall, i_in_data) carries one
//   acquire or release per transaction. The response channel (o_out_valid,
//   i_out_stall, o_out_data) returns exactly one response per request, in
//   order, with the status and any revoke or retry callback.
//   Each request first reads its directory entry from the synchronous
//   RAM, then updates it, writes it back and loads the response
//   register. The response is valid the cycle after the update, and a
//   new request is taken only once the previous update is done.
//   After reset the block sweeps all NUM_LOCKS directory entries, one entry
//   per cycle, with o_in_stall high, so every lock starts absent.
//   When the receiver stalls, the response stays in the output register and
//   one more request may be read; its update waits until the register frees.
module lock_directory_revoke_retry #(
    parameter int NUM_LOCKS   = 256,
    parameter int NUM_CLIENTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ldr_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ldr_pkg::t_rsp o_out_data
);

    ldr_pkg::t_cmd cmd;
    ldr_pkg::t_sts sts;

    // Sequencing of clear, accept and execute.
    ldr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Directory store and entry update.
    ldr_dp #(
        .NUM_LOCKS   (NUM_LOCKS),
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[rtl/ldr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module ldr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ldr_ctrl.sv]
// Controller for the lock directory: clearing sweep, request accept and execute.
// Depends on ldr_pkg for the command and status structs.
module ldr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ldr_pkg::t_sts i_sts,
    output ldr_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register; reset starts the clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands to the datapath.
    assign o_cmd.clear  = (r_state == S_CLEAR);
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec   = (r_state == S_EXEC) && i_sts.out_free;
    assign o_in_stall   = (r_state != S_IDLE);

endmodule

[rtl/ldr_dp.sv]
// Datapath for the lock directory: request capture, entry update and response register.
// Depends on ldr_pkg and instantiates ldr_ram for the directory store.
module ldr_dp #(
    parameter int NUM_LOCKS   = 256,
    parameter int NUM_CLIENTS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ldr_pkg::t_cmd i_cmd,
    output ldr_pkg::t_sts o_sts,
    input  ldr_pkg::t_req i_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ldr_pkg::t_rsp o_out_data
);

    localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int CW = NUM_CLIENTS;
    localparam int EW = 2 + 6 + 1 + 6 + CW;

    // Captured request.
    logic          r_kind;
    logic [7:0]    r_lock;
    logic [5:0]    r_client;
    logic          r_in_range;
    logic [LW-1:0] r_addr;

    // Clearing sweep address.
    logic [LW-1:0] r_clr_addr;

    // Response register.
    logic          r_out_valid;
    ldr_pkg::t_rsp r_out_data;

    // Directory entry fields.
    logic [EW-1:0] rd_entry;
    logic [1:0]    e_mode;
    logic [5:0]    e_holder;
    logic          e_np;
    logic [5:0]    e_nc;
    logic [CW-1:0] e_w;
    logic [1:0]    n_mode;
    logic [5:0]    n_holder;
    logic          n_np;
    logic [5:0]    n_nc;
    logic [CW-1:0] n_w;
    logic [CW-1:0] cbit;
    logic [CW-1:0] lowbit;
    logic [5:0]    low_idx;
    ldr_pkg::t_rsp n_rsp;

    logic          ram_we;
    logic [LW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;

    assign {e_mode, e_holder, e_np, e_nc, e_w} = rd_entry;

    // Capture the request on accept.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind     <= i_req.kind;
            r_lock     <= i_req.lock_id;
            r_client   <= i_req.client_id;
            r_addr     <= LW'(i_req.lock_id);
            r_in_range <= ({24'd0, i_req.lock_id} < 32'(NUM_LOCKS))
                          && ({26'd0, i_req.client_id} < 32'(NUM_CLIENTS));
        end
    end

    // Sweep address for clearing the store after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + LW'(1);
        end
    end

    assign o_sts.clear_last = (r_clr_addr == LW'(NUM_LOCKS - 1));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    // Lowest waiting client.
    always_comb begin
        low_idx = '0;
        for (int i = CW - 1; i >= 0; i--) begin
            if (e_w[i]) begin
                low_idx = 6'(i);
            end
        end
    end

    assign cbit   = {{(CW-1){1'b0}}, 1'b1} << r_client;
    assign lowbit = {{(CW-1){1'b0}}, 1'b1} << low_idx;

    // Entry update and response for the captured request.
    always_comb begin
        n_mode   = e_mode;
        n_holder = e_holder;
        n_np     = e_np;
        n_nc     = e_nc;
        n_w      = e_w;
        n_rsp.status         = ldr_pkg::ST_OK;
        n_rsp.message        = ldr_pkg::MSG_NONE;
        n_rsp.message_client = '0;
        n_rsp.message_lock   = '0;
        if (!r_in_range) begin
            n_rsp.status = ldr_pkg::ST_VIOLATION;
        end else if (r_kind == ldr_pkg::KIND_ACQUIRE) begin
            case (e_mode)
                ldr_pkg::MODE_ABSENT: begin
                    n_mode   = ldr_pkg::MODE_GRANTED;
                    n_holder = r_client;
                    n_np     = 1'b0;
                    n_nc     = '0;
                    n_w      = '0;
                end
                ldr_pkg::MODE_FREE: begin
                    if (!e_np || (e_nc != r_client)) begin
                        n_rsp.status = ldr_pkg::ST_RETRY;
                    end else begin
                        // The next client takes the lock; the lowest waiter moves up.
                        if (|e_w) begin
                            n_w  = e_w & ~lowbit;
                            n_np = 1'b1;
                            n_nc = low_idx;
                        end else begin
                            n_np = 1'b0;
                            n_nc = '0;
                        end
                        n_mode   = ldr_pkg::MODE_GRANTED;
                        n_holder = r_client;
                    end
                end
                ldr_pkg::MODE_GRANTED: begin
                    if (e_holder == r_client) begin
                        n_rsp.status = ldr_pkg::ST_VIOLATION;
                    end else begin
                        n_mode = ldr_pkg::MODE_REVOKING;
                        n_np   = 1'b1;
                        n_nc   = r_client;
                        n_rsp.message        = ldr_pkg::MSG_REVOKE;
                        n_rsp.message_client = e_holder;
                        n_rsp.message_lock   = r_lock;
                    end
                end
                default: begin
                    // Revoking: queue the requester unless already waiting or next.
                    if (!(|(e_w & cbit)) && !(e_np && (e_nc == r_client))) begin
                        n_w = e_w | cbit;
                    end
                    n_rsp.status = ldr_pkg::ST_RETRY;
                end
            endcase
        end else begin
            if ((e_mode != ldr_pkg::MODE_REVOKING) || (e_holder != r_client)) begin
                n_rsp.status = ldr_pkg::ST_VIOLATION;
            end else begin
                n_mode = ldr_pkg::MODE_FREE;
                if (e_np) begin
                    n_rsp.message        = ldr_pkg::MSG_RETRY;
                    n_rsp.message_client = e_nc;
                    n_rsp.message_lock   = r_lock;
                end
            end
        end
    end

    // Store write: zeros during the sweep, the updated entry on execute.
    assign ram_we    = i_cmd.clear || i_cmd.exec;
    assign ram_waddr = i_cmd.clear ? r_clr_addr : r_addr;
    assign ram_wdata = i_cmd.clear ? '0 : {n_mode, n_holder, n_np, n_nc, n_w};

    ldr_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_LOCKS)
    ) u_dir (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (LW'(i_req.lock_id)),
        .o_rdata (rd_entry)
    );

    // Response register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Response register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_data <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
